// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk; ASSERT_CLKD is gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/dtps_pkg.sv
// ----------------------------------------------------------------------------
// dtps_pkg
// Types, codes and constants of the depth-tested pixel store.
// ----------------------------------------------------------------------------
`default_nettype none

package dtps_pkg;

  localparam int CHAN_W  = 12;
  localparam int ALPHA_W = 16;
  localparam int DEPTH_W = 31;
  localparam int FRAME_W = 10;

  localparam logic [CHAN_W-1:0]  INTENSITY_MAX = 12'd4095;
  localparam logic [CHAN_W-1:0]  BG_RED        = 12'd2048;
  localparam logic [CHAN_W-1:0]  BG_GREEN      = 12'd1792;
  localparam logic [CHAN_W-1:0]  BG_BLUE       = 12'd1536;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX     = 31'h7FFF_FFFF;
  localparam logic [FRAME_W-1:0] FRAME_RESET   = 10'd512;

  // item codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // result status codes
  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_OFF_FRAME = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } frame_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [ALPHA_W-1:0] alpha;
    logic [DEPTH_W-1:0] depth;
  } pix_entry_t;

  localparam int ENTRY_W = $bits(pix_entry_t);

  localparam pix_entry_t BG_ENTRY = '{
    red:   BG_RED,
    green: BG_GREEN,
    blue:  BG_BLUE,
    alpha: '0,
    depth: DEPTH_MAX
  };

  function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [15:0] v);
    logic [CHAN_W-1:0] r;
    if (v[15]) begin
      r = '0;
    end else if (v[14:12] != 3'b000) begin
      r = INTENSITY_MAX;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtps_ram.sv
// ----------------------------------------------------------------------------
// dtps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dtps_cfg.sv
// ----------------------------------------------------------------------------
// dtps_cfg
// APB register file holding the active frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output dtps_pkg::frame_cfg_t    frame
);

  import dtps_pkg::*;

  logic [FRAME_W-1:0] frame_width_r, frame_width_nxt;
  logic [FRAME_W-1:0] frame_height_r, frame_height_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (wr_en) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_RESET;
      frame_height_r <= FRAME_RESET;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(32-FRAME_W){1'b0}}, frame_width_r};
      REG_FRAME_HEIGHT: prdata = {{(32-FRAME_W){1'b0}}, frame_height_r};
      default:          prdata = '0;
    endcase
  end

  assign frame.frame_width  = frame_width_r;
  assign frame.frame_height = frame_height_r;

endmodule

`default_nettype wire

// File: rtl/core/depth_tested_pixel_store_core.sv
// ----------------------------------------------------------------------------
// depth_tested_pixel_store_core
// Z-buffered frame store: depth-tested pixel writes and pixel reads.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store, one entry per cycle, loading
// the background colour, zero alpha and maximum depth into all entries with
// busy high. Frame size registers can be written during the sweep. After that
// an item is taken when start is high and busy is low; its result passes the
// evaluate state and the out_ registers and is shown on the out_ ports for
// exactly one cycle with out_valid high. busy stays high in the evaluate state,
// so no new item is taken while the last one is evaluated: the store entry is
// read in the accept cycle, and the depth compare and write-back use the
// registered read data in the next cycle.
// Results are never held; the receiver must take each one as it appears.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module depth_tested_pixel_store_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // item channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic signed [10:0] in_pixel_x,
  input  wire logic signed [10:0] in_pixel_y,
  input  wire logic signed [15:0] in_red_in,
  input  wire logic signed [15:0] in_green_in,
  input  wire logic signed [15:0] in_blue_in,
  input  wire logic signed [15:0] in_alpha_in,
  input  wire logic signed [31:0] in_depth_in,
  // result channel
  output logic                    out_valid,
  output logic                    out_status,
  output logic             [11:0] out_red_out,
  output logic             [11:0] out_green_out,
  output logic             [11:0] out_blue_out,
  output logic signed      [15:0] out_alpha_out,
  output logic             [30:0] out_depth_out,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  import dtps_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  frame_cfg_t frame;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic        accept;
  logic [9:0]  x_u, y_u;
  logic        x_ok, y_ok, in_frame;
  logic [31:0] addr_full;

  // item held for the evaluate cycle
  logic              action_r;
  logic              inside_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;
  logic [15:0]       alpha_r;
  logic [31:0]       depth_r;
  logic [ADDR_W-1:0] addr_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  pix_entry_t        ram_wdata;
  pix_entry_t        rd_entry;
  logic              wr_pass;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r;
  pix_entry_t        out_entry_r;

  dtps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .frame   (frame)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // frame test; the active size is the register capped at the store size
  assign x_u  = in_pixel_x[9:0];
  assign y_u  = in_pixel_y[9:0];
  assign x_ok = !in_pixel_x[10] && (x_u < frame.frame_width) &&
                (32'(x_u) < 32'(MAX_WIDTH));
  assign y_ok = !in_pixel_y[10] && (y_u < frame.frame_height) &&
                (32'(y_u) < 32'(MAX_HEIGHT));
  assign in_frame = x_ok && y_ok;

  assign addr_full = 32'(y_u) * 32'(MAX_WIDTH) + 32'(x_u);

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      inside_r <= in_frame;
      red_r    <= clamp_channel(in_red_in);
      green_r  <= clamp_channel(in_green_in);
      blue_r   <= clamp_channel(in_blue_in);
      alpha_r  <= in_alpha_in;
      depth_r  <= in_depth_in;
      addr_r   <= addr_full[ADDR_W-1:0];
    end
  end

  dtps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (addr_full[ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  // depth test: equal depth overwrites, negative depth never passes
  assign wr_pass = (action_r == ACT_WRITE) && inside_r && !depth_r[31] &&
                   (rd_entry.depth >= depth_r[DEPTH_W-1:0]);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = '{red: red_r, green: green_r, blue: blue_r,
                     alpha: alpha_r, depth: depth_r[DEPTH_W-1:0]};
    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = BG_ENTRY;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ram_we    = wr_pass;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign out_valid_nxt = (state_r == ST_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // writes and off-frame reads return zero fields
  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      if (action_r == ACT_READ && inside_r) begin
        out_entry_r <= rd_entry;
      end else begin
        out_entry_r <= '0;
      end
      if (action_r == ACT_READ && !inside_r) begin
        out_status_r <= STAT_OFF_FRAME;
      end else begin
        out_status_r <= STAT_OK;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_red_out   = out_entry_r.red;
  assign out_green_out = out_entry_r.green;
  assign out_blue_out  = out_entry_r.blue;
  assign out_alpha_out = out_entry_r.alpha;
  assign out_depth_out = out_entry_r.depth;

  `ASSERT_CLKD(a_accept_gives_result, accept |-> ##2 out_valid, "item accepted without result")
  `ASSERT_CLKD(a_result_follows_eval, out_valid |-> $past(state_r) == ST_EVAL, "stray result")
  `ASSERT_CLKD(a_no_result_in_clear, state_r == ST_CLEAR |-> !out_valid, "result during clear")
  `ASSERT_CLKD(a_no_write_when_idle, state_r == ST_IDLE |-> !ram_we, "store written while idle")
  `ASSERT_CLKD(a_off_frame_zero,
    (out_valid && out_status == STAT_OFF_FRAME) |-> (out_depth_out == '0 && out_alpha_out == '0),
    "off-frame read with data")

endmodule

`default_nettype wire
